// ===== src/vrp_pkg.sv =====
// ---------------------------------------------------------------------------
// vrp_pkg - shared types and widths for vertex_rotate_project
// Fixed field widths and the derived datapath widths of every stage.
// ---------------------------------------------------------------------------
`default_nettype none
package vrp_pkg;

  localparam int COORD_W = 16;   // Q8.8 vertex coordinate
  localparam int ANG_W   = 16;   // Q2.14 cosine / sine
  localparam int FRAC_W  = 14;
  localparam int FOV_W   = 15;
  localparam int SCALE_W = 10;
  localparam int CTR_W   = 12;
  localparam int PIX_W   = 16;

  // after the X rotation: 33-bit product sum, floor shift by FRAC_W
  localparam int PROD1_W = COORD_W + ANG_W;
  localparam int ROT1_W  = PROD1_W + 1 - FRAC_W;
  // after the Y rotation
  localparam int PROD2_W = ROT1_W + ANG_W;
  localparam int ROT2_W  = PROD2_W + 1 - FRAC_W;
  // fov + z2
  localparam int DEN_W   = ((ROT2_W > FOV_W + 1) ? ROT2_W : FOV_W + 1) + 1;
  localparam int K_W     = FOV_W + SCALE_W;
  localparam int NUM_W   = ROT2_W + K_W + 1;
  // magnitude of the numerator with the /256 already taken out
  localparam int DIV_W   = NUM_W - 8;
  // divider remainder, one bit over the divisor
  localparam int REM_W   = DEN_W + 1;

  localparam logic [4:0] ADDR_COS   = 5'd0;
  localparam logic [4:0] ADDR_SIN   = 5'd4;
  localparam logic [4:0] ADDR_FOV   = 5'd8;
  localparam logic [4:0] ADDR_SCALE = 5'd12;
  localparam logic [4:0] ADDR_CX    = 5'd16;
  localparam logic [4:0] ADDR_CY    = 5'd20;

  typedef struct packed {
    logic behind;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage
`default_nettype wire

// ===== src/vrp_rotate.sv =====
// ---------------------------------------------------------------------------
// vrp_rotate - X then Y rotation
// Four stages: products, floor-shifted sums, products, floor-shifted sums.
// ---------------------------------------------------------------------------
`default_nettype none
module vrp_rotate (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic signed [vrp_pkg::COORD_W-1:0]  vx,
  input  wire logic signed [vrp_pkg::COORD_W-1:0]  vy,
  input  wire logic signed [vrp_pkg::COORD_W-1:0]  vz,
  input  wire logic signed [vrp_pkg::ANG_W-1:0]    cos_a,
  input  wire logic signed [vrp_pkg::ANG_W-1:0]    sin_a,
  output logic                                     out_valid,
  output logic signed [vrp_pkg::ROT2_W-1:0]        x2,
  output logic signed [vrp_pkg::ROT1_W-1:0]        y1_o,
  output logic signed [vrp_pkg::ROT2_W-1:0]        z2
);
  import vrp_pkg::*;

  logic [3:0] vld;

  logic signed [PROD1_W-1:0] p_cy, p_sz, p_sy, p_cz;
  logic signed [COORD_W-1:0] x_s1, x_s2;
  logic signed [ROT1_W-1:0]  y1, z1, y1_s3;
  logic signed [PROD1_W-1:0] q_cx, q_sx;
  logic signed [PROD2_W-1:0] q_sz, q_cz;
  logic signed [PROD1_W:0]   sum_y1, sum_z1;
  logic signed [PROD2_W:0]   sum_x2, sum_z2;

  assign sum_y1 = PROD1_W'(p_cy) - PROD1_W'(p_sz) + (PROD1_W+1)'(0);
  assign sum_z1 = (PROD1_W+1)'(p_sy) + (PROD1_W+1)'(p_cz);
  assign sum_x2 = (PROD2_W+1)'(q_cx) - (PROD2_W+1)'(q_sz);
  assign sum_z2 = (PROD2_W+1)'(q_sx) + (PROD2_W+1)'(q_cz);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cy  <= cos_a * vy;
      p_sz  <= sin_a * vz;
      p_sy  <= sin_a * vy;
      p_cz  <= cos_a * vz;
      x_s1  <= vx;
      // arithmetic right shift by the fraction width is a floor
      y1    <= sum_y1[PROD1_W:FRAC_W];
      z1    <= sum_z1[PROD1_W:FRAC_W];
      x_s2  <= x_s1;
      q_cx  <= cos_a * x_s2;
      q_sx  <= sin_a * x_s2;
      q_sz  <= sin_a * z1;
      q_cz  <= cos_a * z1;
      y1_s3 <= y1;
      x2    <= sum_x2[PROD2_W:FRAC_W];
      z2    <= sum_z2[PROD2_W:FRAC_W];
      y1_o  <= y1_s3;
    end
  end

  assign out_valid = vld[3];

endmodule
`default_nettype wire

// ===== src/vrp_prep.sv =====
// ---------------------------------------------------------------------------
// vrp_prep - projection numerators and divisor
// Three stages: denominator and fov*scale, numerators, magnitudes.
// ---------------------------------------------------------------------------
`default_nettype none
module vrp_prep (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic signed [vrp_pkg::ROT2_W-1:0]  x2,
  input  wire logic signed [vrp_pkg::ROT1_W-1:0]  y1,
  input  wire logic signed [vrp_pkg::ROT2_W-1:0]  z2,
  input  wire logic [vrp_pkg::FOV_W-1:0]          fov,
  input  wire logic [vrp_pkg::SCALE_W-1:0]        scale,
  output logic                                    out_valid,
  output logic [vrp_pkg::DIV_W-1:0]               mag_x,
  output logic [vrp_pkg::DIV_W-1:0]               mag_y,
  output logic [vrp_pkg::DEN_W-1:0]               divisor,
  output vrp_pkg::side_t                          side
);
  import vrp_pkg::*;

  logic [2:0] vld;

  logic signed [DEN_W-1:0]   den_s1, den_s2;
  logic [K_W-1:0]            k_s1;
  logic signed [ROT2_W-1:0]  x_s1;
  logic signed [ROT1_W-1:0]  y_s1;
  logic signed [NUM_W-1:0]   nx, ny;
  logic [NUM_W-1:0]          ax, ay;

  assign ax = nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
  assign ay = ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s1      <= $signed({{(DEN_W-FOV_W){1'b0}}, fov}) + DEN_W'(z2);
      k_s1        <= K_W'(fov) * K_W'(scale);
      x_s1        <= x2;
      y_s1        <= y1;
      nx          <= NUM_W'(x_s1) * NUM_W'($signed({1'b0, k_s1}));
      ny          <= NUM_W'(y_s1) * NUM_W'($signed({1'b0, k_s1}));
      den_s2      <= den_s1;
      // |n| / (256 d) truncated equals floor(|n| / 256) / d
      mag_x       <= ax[NUM_W-1:8];
      mag_y       <= ay[NUM_W-1:8];
      divisor     <= den_s2;
      side.behind <= (den_s2[DEN_W-1] || den_s2 == '0);
      side.neg_x  <= nx[NUM_W-1];
      side.neg_y  <= ny[NUM_W-1];
    end
  end

  assign out_valid = vld[2];

endmodule
`default_nettype wire

// ===== src/vrp_divide.sv =====
// ---------------------------------------------------------------------------
// vrp_divide - pipelined restoring divider, two lanes
// One quotient bit per stage; dividend bits shift out as quotient bits enter.
// ---------------------------------------------------------------------------
`default_nettype none
module vrp_divide (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [vrp_pkg::DIV_W-1:0]     mag_x,
  input  wire logic [vrp_pkg::DIV_W-1:0]     mag_y,
  input  wire logic [vrp_pkg::DEN_W-1:0]     divisor,
  input  wire vrp_pkg::side_t                side_in,
  output logic                               out_valid,
  output logic [vrp_pkg::DIV_W-1:0]          quot_x,
  output logic [vrp_pkg::DIV_W-1:0]          quot_y,
  output vrp_pkg::side_t                     side_out
);
  import vrp_pkg::*;

  logic [DIV_W-1:0] vld;
  logic [DIV_W-1:0] ax  [DIV_W+1];
  logic [DIV_W-1:0] ay  [DIV_W+1];
  logic [REM_W-1:0] rx  [DIV_W+1];
  logic [REM_W-1:0] ry  [DIV_W+1];
  logic [DEN_W-1:0] dv  [DIV_W+1];
  side_t            sd  [DIV_W+1];

  assign ax[0] = mag_x;
  assign ay[0] = mag_y;
  assign rx[0] = '0;
  assign ry[0] = '0;
  assign dv[0] = divisor;
  assign sd[0] = side_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_W-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < DIV_W; i++) begin : g_step
    logic [REM_W-1:0] shx, shy;
    logic [REM_W:0]   dfx, dfy;

    assign shx = {rx[i][REM_W-2:0], ax[i][DIV_W-1]};
    assign shy = {ry[i][REM_W-2:0], ay[i][DIV_W-1]};
    assign dfx = {1'b0, shx} - {2'b00, dv[i]};
    assign dfy = {1'b0, shy} - {2'b00, dv[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rx[i+1] <= dfx[REM_W] ? shx : dfx[REM_W-1:0];
        ry[i+1] <= dfy[REM_W] ? shy : dfy[REM_W-1:0];
        ax[i+1] <= {ax[i][DIV_W-2:0], ~dfx[REM_W]};
        ay[i+1] <= {ay[i][DIV_W-2:0], ~dfy[REM_W]};
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = vld[DIV_W-1];
  assign quot_x    = ax[DIV_W];
  assign quot_y    = ay[DIV_W];
  assign side_out  = sd[DIV_W];

endmodule
`default_nettype wire

// ===== src/vertex_rotate_project.sv =====
// ---------------------------------------------------------------------------
// vertex_rotate_project - rotate a vertex about X and Y, then project it
// Registers, pipeline control and the final center add with saturation.
// ---------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata = vertex_x, vertex_y, vertex_z
//  m_axis    out  tdata = screen_x, screen_y; tuser = behind_viewer, saturated
//  apb       in   six registers at byte addresses 0..20
//
//  One vertex per clock unless the output stalls; the divider yields
//  one quotient bit per stage, so its depth follows DIV_W.
//  Every stage advances when the output register is empty or being taken,
//  so a stall freezes the whole pipe and nothing is lost.
//  Reset clears the valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none
module vertex_rotate_project (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // vertex_x, vertex_y, vertex_z
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // screen_x, screen_y
  output logic [1:0]       m_tuser,   // behind_viewer, saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import vrp_pkg::*;

  logic signed [ANG_W-1:0] cos_angle, sin_angle;
  logic [FOV_W-1:0]        field_of_view;
  logic [SCALE_W-1:0]      projection_scale;
  logic [CTR_W-1:0]        center_x, center_y;

  logic en;

  logic                     rot_valid;
  logic signed [ROT2_W-1:0] x2, z2;
  logic signed [ROT1_W-1:0] y1;

  logic               prep_valid;
  logic [DIV_W-1:0]   mag_x, mag_y;
  logic [DEN_W-1:0]   divisor;
  side_t              prep_side;

  logic               div_valid;
  logic [DIV_W-1:0]   quot_x, quot_y;
  side_t              div_side;

  logic signed [DIV_W+1:0] sum_x, sum_y;
  logic [PIX_W-1:0]        pix_x, pix_y;
  logic                    sat_x, sat_y;

  assign pready   = 1'b1;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle        <= 16'sd16384;
      sin_angle        <= '0;
      field_of_view    <= 15'd768;
      projection_scale <= 10'd100;
      center_x         <= 12'd320;
      center_y         <= 12'd240;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_COS:   cos_angle        <= pwdata[ANG_W-1:0];
        ADDR_SIN:   sin_angle        <= pwdata[ANG_W-1:0];
        ADDR_FOV:   field_of_view    <= pwdata[FOV_W-1:0];
        ADDR_SCALE: projection_scale <= pwdata[SCALE_W-1:0];
        ADDR_CX:    center_x         <= pwdata[CTR_W-1:0];
        ADDR_CY:    center_y         <= pwdata[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_COS:   prdata = {16'd0, cos_angle};
      ADDR_SIN:   prdata = {16'd0, sin_angle};
      ADDR_FOV:   prdata = {17'd0, field_of_view};
      ADDR_SCALE: prdata = {22'd0, projection_scale};
      ADDR_CX:    prdata = {20'd0, center_x};
      ADDR_CY:    prdata = {20'd0, center_y};
      default:    prdata = '0;
    endcase
  end

  vrp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .vx        (s_tdata[15:0]),
    .vy        (s_tdata[31:16]),
    .vz        (s_tdata[47:32]),
    .cos_a     (cos_angle),
    .sin_a     (sin_angle),
    .out_valid (rot_valid),
    .x2        (x2),
    .y1_o      (y1),
    .z2        (z2)
  );

  vrp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .x2        (x2),
    .y1        (y1),
    .z2        (z2),
    .fov       (field_of_view),
    .scale     (projection_scale),
    .out_valid (prep_valid),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .divisor   (divisor),
    .side      (prep_side)
  );

  vrp_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .divisor   (divisor),
    .side_in   (prep_side),
    .out_valid (div_valid),
    .quot_x    (quot_x),
    .quot_y    (quot_y),
    .side_out  (div_side)
  );

  // signed quotient plus center, then clamp to the pixel range
  assign sum_x = (div_side.neg_x ? -$signed({2'b00, quot_x}) : $signed({2'b00, quot_x}))
               + $signed({{(DIV_W+2-CTR_W){1'b0}}, center_x});
  assign sum_y = (div_side.neg_y ? -$signed({2'b00, quot_y}) : $signed({2'b00, quot_y}))
               + $signed({{(DIV_W+2-CTR_W){1'b0}}, center_y});

  always_comb begin
    sat_x = 1'b0;
    pix_x = sum_x[PIX_W-1:0];
    if (sum_x > (DIV_W+2)'(32767)) begin
      sat_x = 1'b1;
      pix_x = 16'h7fff;
    end else if (sum_x < -(DIV_W+2)'(32768)) begin
      sat_x = 1'b1;
      pix_x = 16'h8000;
    end
    sat_y = 1'b0;
    pix_y = sum_y[PIX_W-1:0];
    if (sum_y > (DIV_W+2)'(32767)) begin
      sat_y = 1'b1;
      pix_y = 16'h7fff;
    end else if (sum_y < -(DIV_W+2)'(32768)) begin
      sat_y = 1'b1;
      pix_y = 16'h8000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (div_side.behind) begin
        m_tdata <= {{(PIX_W-CTR_W){1'b0}}, center_y, {(PIX_W-CTR_W){1'b0}}, center_x};
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {pix_y, pix_x};
        m_tuser <= {sat_x || sat_y, 1'b0};
      end
    end
  end

endmodule
`default_nettype wire
